// ===== design/fftag_pkg.sv =====
package fftag_pkg;

   localparam int HEAP_BYTES_DEF   = 4096;
   localparam int HEADER_BYTES_DEF = 16;
   localparam int FOOTER_BYTES_DEF = 8;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef struct packed {
      logic hd_rd;
      logic hd_wr;
      logic ft_rd;
      logic ft_wr;
   } tag_ctl_type;

   typedef enum logic [5:0] {
      S_CLEAR, S_IDLE, S_FAIL, S_DONE,
      A_NEED, A_CHK, A_RD, A_TEST, A_ADV1, A_ADV2, A_SPL, A_PICK, A_DONE,
      W_HEAD, W_FOOT, W_REM, W_CHK, W_LOOK,
      L_RD, L_TEST, L_ADV,
      P_HEAD, P_FOOT, P_NB, P_NSZ, P_NHEAD, P_NFOOT, P_FF, P_REM,
      F_SUB, F_RD, F_TEST, F_FOOT, F_REM, F_PRE, F_PTEST, F_MADD, F_MW, F_MREM,
      N_ADD, N_NXT, N_TEST, N_FOOT, N_SUM, N_HW, N_REM, F_FF
   } state_type;

endpackage

// ===== design/fftag_alu.sv =====
module fftag_alu import fftag_pkg::*; #(
   parameter int VW = 15
) (
   input  logic [VW-1:0] alu_a,
   input  logic [VW-1:0] alu_b,
   input  logic          alu_sub,
   output logic [VW-1:0] alu_res,
   output logic          alu_lt
);

   logic [VW:0] diff;

   assign diff    = {1'b0, alu_a} - {1'b0, alu_b};
   assign alu_res = alu_sub ? diff[VW-1:0] : alu_a + alu_b;
   assign alu_lt  = diff[VW];

endmodule

// ===== design/fftag_tags.sv =====
module fftag_tags import fftag_pkg::*; #(
   parameter int SPAN = 4120,
   parameter int MW   = 13,
   parameter int AW   = 14,
   parameter int SW   = 13
) (
   input  logic          clock,
   input  tag_ctl_type   ctl,
   input  logic [AW-1:0] hd_rd_addr,
   input  logic [AW-1:0] hd_wr_addr,
   input  logic [SW-1:0] hd_wr_size,
   input  logic          hd_wr_alive,
   input  logic [7:0]    hd_wr_owner,
   output logic [SW-1:0] hd_rd_size,
   output logic          hd_rd_alive,
   output logic [7:0]    hd_rd_owner,
   input  logic [AW-1:0] ft_rd_addr,
   input  logic [AW-1:0] ft_wr_addr,
   input  logic [MW-1:0] ft_wr_top,
   input  logic          ft_wr_alive,
   output logic [MW-1:0] ft_rd_top,
   output logic          ft_rd_alive
);

   logic [SW+8:0] head_mem [SPAN];
   logic [MW:0]   foot_mem [SPAN];
   logic [SW+8:0] hd_q_ff;
   logic [MW:0]   ft_q_ff;
   logic          hd_oob_ff;
   logic          ft_oob_ff;

   always_ff @(posedge clock) begin
      if (ctl.hd_wr && hd_wr_addr < AW'(SPAN)) begin
         head_mem[hd_wr_addr[MW-1:0]] <= {hd_wr_size, hd_wr_alive, hd_wr_owner};
      end
      if (ctl.hd_rd) begin
         hd_oob_ff <= !(hd_rd_addr < AW'(SPAN));
         hd_q_ff   <= head_mem[hd_rd_addr[MW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ft_wr && ft_wr_addr < AW'(SPAN)) begin
         foot_mem[ft_wr_addr[MW-1:0]] <= {ft_wr_top, ft_wr_alive};
      end
      if (ctl.ft_rd) begin
         ft_oob_ff <= !(ft_rd_addr < AW'(SPAN));
         ft_q_ff   <= foot_mem[ft_rd_addr[MW-1:0]];
      end
   end

   assign hd_rd_size  = hd_oob_ff ? '0 : hd_q_ff[SW+8:9];
   assign hd_rd_alive = hd_oob_ff ? 1'b0 : hd_q_ff[8];
   assign hd_rd_owner = hd_oob_ff ? '0 : hd_q_ff[7:0];
   assign ft_rd_top   = ft_oob_ff ? '0 : ft_q_ff[MW:1];
   assign ft_rd_alive = ft_oob_ff ? 1'b0 : ft_q_ff[0];

endmodule

// ===== design/first_fit_boundary_tag_allocator.sv =====
// allocate walks the blocks from the first free one and splits the block it takes, or
//    takes it whole and then, when that was the first free block, scans past busy blocks
//    for the new first free block; a rejected allocate or free goes to the fail state
// one transaction at a time, next request taken only after the response has been issued
// reset: a clearing pass writes all HEAP_BYTES + HEADER_BYTES + FOOTER_BYTES tag memory
//    entries (4120 at defaults), no request is taken meanwhile
module first_fit_boundary_tag_allocator import fftag_pkg::*; #(
   parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF,
   parameter int FOOTER_BYTES = FOOTER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [12:0] req_req_bytes,
   input  logic [11:0] req_payload_offset,
   input  logic [7:0]  req_owner_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_ok,
   output logic [11:0] rsp_result_offset,
   output logic [12:0] rsp_free_bytes
);

   localparam int TAG_BYTES = HEADER_BYTES + FOOTER_BYTES;
   localparam int SPARE_MIN = TAG_BYTES + 4;
   localparam int SPAN      = HEAP_BYTES + TAG_BYTES;
   localparam int MW        = $clog2(SPAN);
   localparam int AW        = MW + 1;
   localparam int VW        = ((AW > 13) ? AW : 13) + 1;
   localparam int SW        = $clog2(HEAP_BYTES + 1);

   localparam logic [VW-1:0] TAGV  = VW'(TAG_BYTES);
   localparam logic [VW-1:0] HDRV  = VW'(HEADER_BYTES);
   localparam logic [VW-1:0] FTRV  = VW'(FOOTER_BYTES);
   localparam logic [VW-1:0] SPANV = VW'(SPAN);

   state_type state_ff, state_in;

   logic [MW-1:0] clr_ff, clr_in;
   logic [VW-1:0] req_ff, req_in;
   logic [VW-1:0] pay_ff, pay_in;
   logic [7:0]    own_ff, own_in;
   logic [VW-1:0] cur_ff, cur_in;
   logic [VW-1:0] nxt_ff, nxt_in;
   logic [VW-1:0] sum_ff, sum_in;
   logic [VW-1:0] dif_ff, dif_in;
   logic [VW-1:0] prev_ff, prev_in;
   logic [VW-1:0] bsz_ff, bsz_in;
   logic [VW-1:0] fa_ff, fa_in;
   logic [VW-1:0] first_free_ff, first_free_in;
   logic          none_free_ff, none_free_in;
   logic [VW-1:0] remaining_ff, remaining_in;
   logic          hal_ff, hal_in;
   logic [7:0]    how_ff, how_in;
   logic          ok_ff, ok_in;
   logic [11:0]   off_ff, off_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_ok_ff, rsp_ok_in;
   logic [11:0]   rsp_off_ff, rsp_off_in;
   logic [12:0]   rsp_free_ff, rsp_free_in;

   tag_ctl_type   ctl;
   logic [AW-1:0] hd_rd_addr, hd_wr_addr, ft_rd_addr, ft_wr_addr;
   logic [SW-1:0] hd_wr_size, hd_rd_size;
   logic          hd_wr_alive, hd_rd_alive, ft_wr_alive, ft_rd_alive;
   logic [7:0]    hd_wr_owner, hd_rd_owner;
   logic [MW-1:0] ft_wr_top, ft_rd_top;
   logic [VW-1:0] hsz;
   logic [VW-1:0] alu_a, alu_b, alu_res;
   logic          alu_sub, alu_lt;
   logic          out_free;

   assign hsz      = VW'(hd_rd_size);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   fftag_alu #(.VW(VW)) u_alu (
      .alu_a   (alu_a),
      .alu_b   (alu_b),
      .alu_sub (alu_sub),
      .alu_res (alu_res),
      .alu_lt  (alu_lt)
   );

   fftag_tags #(.SPAN(SPAN), .MW(MW), .AW(AW), .SW(SW)) u_tags (
      .clock       (clock),
      .ctl         (ctl),
      .hd_rd_addr  (hd_rd_addr),
      .hd_wr_addr  (hd_wr_addr),
      .hd_wr_size  (hd_wr_size),
      .hd_wr_alive (hd_wr_alive),
      .hd_wr_owner (hd_wr_owner),
      .hd_rd_size  (hd_rd_size),
      .hd_rd_alive (hd_rd_alive),
      .hd_rd_owner (hd_rd_owner),
      .ft_rd_addr  (ft_rd_addr),
      .ft_wr_addr  (ft_wr_addr),
      .ft_wr_top   (ft_wr_top),
      .ft_wr_alive (ft_wr_alive),
      .ft_rd_top   (ft_rd_top),
      .ft_rd_alive (ft_rd_alive)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (clr_ff == MW'(SPAN - 1)) state_in = S_IDLE;
         S_IDLE: begin
            if (req_valid) state_in = (req_cmd == CMD_FREE) ? F_SUB : A_NEED;
         end
         S_FAIL:  state_in = S_DONE;
         S_DONE:  if (out_free) state_in = S_IDLE;
         A_NEED:  state_in = A_CHK;
         A_CHK:   state_in = (none_free_ff || alu_lt) ? S_FAIL : A_RD;
         A_RD:    state_in = A_TEST;
         A_TEST: begin
            if (!(cur_ff < SPANV)) state_in = S_FAIL;
            else if (alu_lt || hd_rd_alive) state_in = A_ADV1;
            else state_in = A_SPL;
         end
         A_ADV1:  state_in = A_ADV2;
         A_ADV2:  state_in = (alu_res > VW'(HEAP_BYTES + HEADER_BYTES)) ? S_FAIL : A_RD;
         A_SPL:   state_in = A_PICK;
         A_PICK:  state_in = (dif_ff < VW'(SPARE_MIN)) ? W_HEAD : P_HEAD;
         A_DONE:  state_in = S_DONE;
         W_HEAD:  state_in = W_FOOT;
         W_FOOT:  state_in = W_REM;
         W_REM:   state_in = W_CHK;
         W_CHK:   state_in = (remaining_ff == '0 || alu_lt) ? A_DONE : W_LOOK;
         W_LOOK:  state_in = L_RD;
         L_RD:    state_in = (nxt_ff < SPANV) ? L_TEST : A_DONE;
         L_TEST:  state_in = hd_rd_alive ? L_ADV : A_DONE;
         L_ADV:   state_in = L_RD;
         P_HEAD:  state_in = P_FOOT;
         P_FOOT:  state_in = P_NB;
         P_NB:    state_in = P_NSZ;
         P_NSZ:   state_in = P_NHEAD;
         P_NHEAD: state_in = P_NFOOT;
         P_NFOOT: state_in = P_FF;
         P_FF:    state_in = P_REM;
         P_REM:   state_in = A_DONE;
         F_SUB:   state_in = (pay_ff < HDRV) ? S_FAIL : F_RD;
         F_RD:    state_in = F_TEST;
         F_TEST:  state_in = hd_rd_alive ? F_FOOT : S_FAIL;
         F_FOOT:  state_in = F_REM;
         F_REM:   state_in = F_PRE;
         F_PRE:   state_in = (cur_ff < FTRV) ? N_ADD : F_PTEST;
         F_PTEST: begin
            state_in = (!ft_rd_alive && VW'(ft_rd_top) < SPANV) ? F_MADD : N_ADD;
         end
         F_MADD:  state_in = F_MW;
         F_MW:    state_in = F_MREM;
         F_MREM:  state_in = N_ADD;
         N_ADD:   state_in = N_NXT;
         N_NXT:   state_in = N_TEST;
         N_TEST:  state_in = (nxt_ff < SPANV && !hd_rd_alive) ? N_FOOT : F_FF;
         N_FOOT:  state_in = N_SUM;
         N_SUM:   state_in = N_HW;
         N_HW:    state_in = N_REM;
         N_REM:   state_in = F_FF;
         F_FF:    state_in = S_DONE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      clr_in        = clr_ff;
      req_in        = req_ff;
      pay_in        = pay_ff;
      own_in        = own_ff;
      cur_in        = cur_ff;
      nxt_in        = nxt_ff;
      sum_in        = sum_ff;
      dif_in        = dif_ff;
      prev_in       = prev_ff;
      bsz_in        = bsz_ff;
      fa_in         = fa_ff;
      first_free_in = first_free_ff;
      none_free_in  = none_free_ff;
      remaining_in  = remaining_ff;
      hal_in        = hal_ff;
      how_in        = how_ff;
      ok_in         = ok_ff;
      off_in        = off_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_ok_in     = rsp_ok_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_free_in   = rsp_free_ff;
      ctl           = '0;
      hd_rd_addr    = '0;
      hd_wr_addr    = '0;
      hd_wr_size    = '0;
      hd_wr_alive   = 1'b0;
      hd_wr_owner   = '0;
      ft_rd_addr    = '0;
      ft_wr_addr    = '0;
      ft_wr_top     = '0;
      ft_wr_alive   = 1'b0;
      alu_a         = '0;
      alu_b         = '0;
      alu_sub       = 1'b0;
      req_stall     = 1'b1;
      unique case (state_ff)
         S_CLEAR: begin
            ctl.hd_wr  = 1'b1;
            ctl.ft_wr  = 1'b1;
            hd_wr_addr = AW'(clr_ff);
            ft_wr_addr = AW'(clr_ff);
            hd_wr_size = (clr_ff == '0) ? SW'(HEAP_BYTES) : '0;
            clr_in     = clr_ff + 1'b1;
         end
         S_IDLE: begin
            req_stall = 1'b0;
            req_in    = VW'(req_req_bytes);
            pay_in    = VW'(req_payload_offset);
            own_in    = req_owner_id;
         end
         S_FAIL: begin
            ok_in  = 1'b0;
            off_in = '0;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_off_in   = off_ff;
               rsp_free_in  = remaining_ff[12:0];
            end
         end
         A_NEED: begin
            alu_a  = req_ff;
            alu_b  = TAGV;
            sum_in = alu_res;
         end
         A_CHK: begin
            alu_a   = remaining_ff;
            alu_b   = sum_ff;
            alu_sub = 1'b1;
            cur_in  = first_free_ff;
         end
         A_RD: begin
            ctl.hd_rd  = 1'b1;
            hd_rd_addr = cur_ff[AW-1:0];
         end
         A_TEST: begin
            alu_a   = hsz;
            alu_b   = req_ff;
            alu_sub = 1'b1;
            prev_in = hsz;
         end
         A_ADV1: begin
            alu_a  = cur_ff;
            alu_b  = prev_ff;
            sum_in = alu_res;
         end
         A_ADV2: begin
            alu_a  = sum_ff;
            alu_b  = TAGV;
            cur_in = alu_res;
         end
         A_SPL: begin
            alu_a   = prev_ff;
            alu_b   = req_ff;
            alu_sub = 1'b1;
            dif_in  = alu_res;
         end
         A_PICK: begin
         end
         A_DONE: begin
            alu_a  = cur_ff;
            alu_b  = HDRV;
            ok_in  = 1'b1;
            off_in = alu_res[11:0];
         end
         W_HEAD: begin
            ctl.hd_wr   = 1'b1;
            hd_wr_addr  = cur_ff[AW-1:0];
            hd_wr_size  = prev_ff[SW-1:0];
            hd_wr_alive = 1'b1;
            hd_wr_owner = own_ff;
            alu_a       = cur_ff;
            alu_b       = prev_ff;
            sum_in      = alu_res;
         end
         W_FOOT: begin
            alu_a       = sum_ff;
            alu_b       = HDRV;
            ctl.ft_wr   = 1'b1;
            ft_wr_addr  = alu_res[AW-1:0];
            ft_wr_top   = cur_ff[MW-1:0];
            ft_wr_alive = 1'b1;
         end
         W_REM: begin
            alu_a        = remaining_ff;
            alu_b        = prev_ff;
            alu_sub      = 1'b1;
            remaining_in = alu_res;
         end
         W_CHK: begin
            alu_a   = first_free_ff;
            alu_b   = cur_ff;
            alu_sub = 1'b1;
            if (remaining_ff == '0) none_free_in = 1'b1;
         end
         W_LOOK: begin
            alu_a  = sum_ff;
            alu_b  = TAGV;
            nxt_in = alu_res;
         end
         L_RD: begin
            if (nxt_ff < SPANV) begin
               ctl.hd_rd  = 1'b1;
               hd_rd_addr = nxt_ff[AW-1:0];
            end else begin
               none_free_in = 1'b1;
            end
         end
         L_TEST: begin
            alu_a  = nxt_ff;
            alu_b  = hsz;
            sum_in = alu_res;
            if (!hd_rd_alive) first_free_in = nxt_ff;
         end
         L_ADV: begin
            alu_a  = sum_ff;
            alu_b  = TAGV;
            nxt_in = alu_res;
         end
         P_HEAD: begin
            ctl.hd_wr   = 1'b1;
            hd_wr_addr  = cur_ff[AW-1:0];
            hd_wr_size  = req_ff[SW-1:0];
            hd_wr_alive = 1'b1;
            hd_wr_owner = own_ff;
            alu_a       = cur_ff;
            alu_b       = req_ff;
            sum_in      = alu_res;
         end
         P_FOOT: begin
            alu_a       = sum_ff;
            alu_b       = HDRV;
            ctl.ft_wr   = 1'b1;
            ft_wr_addr  = alu_res[AW-1:0];
            ft_wr_top   = cur_ff[MW-1:0];
            ft_wr_alive = 1'b1;
         end
         P_NB: begin
            alu_a  = sum_ff;
            alu_b  = TAGV;
            nxt_in = alu_res;
         end
         P_NSZ: begin
            alu_a   = dif_ff;
            alu_b   = TAGV;
            alu_sub = 1'b1;
            prev_in = alu_res;
         end
         P_NHEAD: begin
            ctl.hd_wr  = 1'b1;
            hd_wr_addr = nxt_ff[AW-1:0];
            hd_wr_size = prev_ff[SW-1:0];
            alu_a      = nxt_ff;
            alu_b      = prev_ff;
            sum_in     = alu_res;
         end
         P_NFOOT: begin
            alu_a      = sum_ff;
            alu_b      = HDRV;
            ctl.ft_wr  = 1'b1;
            ft_wr_addr = alu_res[AW-1:0];
            ft_wr_top  = nxt_ff[MW-1:0];
         end
         P_FF: begin
            alu_a  = req_ff;
            alu_b  = TAGV;
            sum_in = alu_res;
            if (cur_ff == first_free_ff) first_free_in = nxt_ff;
         end
         P_REM: begin
            alu_a        = remaining_ff;
            alu_b        = sum_ff;
            alu_sub      = 1'b1;
            remaining_in = alu_res;
         end
         F_SUB: begin
            alu_a   = pay_ff;
            alu_b   = HDRV;
            alu_sub = 1'b1;
            cur_in  = alu_res;
         end
         F_RD: begin
            ctl.hd_rd  = 1'b1;
            hd_rd_addr = cur_ff[AW-1:0];
         end
         F_TEST: begin
            prev_in    = hsz;
            bsz_in     = hsz;
            hal_in     = 1'b0;
            how_in     = '0;
            alu_a      = cur_ff;
            alu_b      = hsz;
            sum_in     = alu_res;
            if (hd_rd_alive) begin
               ctl.hd_wr  = 1'b1;
               hd_wr_addr = cur_ff[AW-1:0];
               hd_wr_size = hd_rd_size;
            end
         end
         F_FOOT: begin
            alu_a      = sum_ff;
            alu_b      = HDRV;
            fa_in      = alu_res;
            ctl.ft_wr  = 1'b1;
            ft_wr_addr = alu_res[AW-1:0];
            ft_wr_top  = cur_ff[MW-1:0];
         end
         F_REM: begin
            alu_a        = remaining_ff;
            alu_b        = prev_ff;
            remaining_in = alu_res;
         end
         F_PRE: begin
            alu_a   = cur_ff;
            alu_b   = FTRV;
            alu_sub = 1'b1;
            if (!(cur_ff < FTRV)) begin
               ctl.ft_rd  = 1'b1;
               ft_rd_addr = alu_res[AW-1:0];
            end
         end
         F_PTEST: begin
            if (!ft_rd_alive && VW'(ft_rd_top) < SPANV) begin
               nxt_in     = VW'(ft_rd_top);
               ctl.hd_rd  = 1'b1;
               hd_rd_addr = AW'(ft_rd_top);
            end
         end
         F_MADD: begin
            alu_a  = hsz;
            alu_b  = prev_ff;
            sum_in = alu_res;
         end
         F_MW: begin
            alu_a       = sum_ff;
            alu_b       = TAGV;
            bsz_in      = alu_res;
            ctl.hd_wr   = 1'b1;
            hd_wr_addr  = nxt_ff[AW-1:0];
            hd_wr_size  = alu_res[SW-1:0];
            hd_wr_alive = hd_rd_alive;
            hd_wr_owner = hd_rd_owner;
            hal_in      = hd_rd_alive;
            how_in      = hd_rd_owner;
            ctl.ft_wr   = 1'b1;
            ft_wr_addr  = fa_ff[AW-1:0];
            ft_wr_top   = nxt_ff[MW-1:0];
            cur_in      = nxt_ff;
         end
         F_MREM, N_REM: begin
            alu_a        = remaining_ff;
            alu_b        = TAGV;
            remaining_in = alu_res;
         end
         N_ADD: begin
            alu_a  = cur_ff;
            alu_b  = bsz_ff;
            sum_in = alu_res;
         end
         N_NXT: begin
            alu_a      = sum_ff;
            alu_b      = TAGV;
            nxt_in     = alu_res;
            ctl.hd_rd  = 1'b1;
            hd_rd_addr = alu_res[AW-1:0];
         end
         N_TEST: begin
            prev_in = hsz;
            alu_a   = nxt_ff;
            alu_b   = hsz;
            sum_in  = alu_res;
         end
         N_FOOT: begin
            alu_a      = sum_ff;
            alu_b      = HDRV;
            ctl.ft_wr  = 1'b1;
            ft_wr_addr = alu_res[AW-1:0];
            ft_wr_top  = cur_ff[MW-1:0];
         end
         N_SUM: begin
            alu_a  = bsz_ff;
            alu_b  = prev_ff;
            sum_in = alu_res;
         end
         N_HW: begin
            alu_a       = sum_ff;
            alu_b       = TAGV;
            ctl.hd_wr   = 1'b1;
            hd_wr_addr  = cur_ff[AW-1:0];
            hd_wr_size  = alu_res[SW-1:0];
            hd_wr_alive = hal_ff;
            hd_wr_owner = how_ff;
         end
         F_FF: begin
            alu_a   = cur_ff;
            alu_b   = first_free_ff;
            alu_sub = 1'b1;
            ok_in   = 1'b1;
            off_in  = '0;
            if (none_free_ff || alu_lt) begin
               first_free_in = cur_ff;
               none_free_in  = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         first_free_ff <= '0;
         none_free_ff  <= 1'b0;
         remaining_ff  <= VW'(HEAP_BYTES);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         first_free_ff <= first_free_in;
         none_free_ff  <= none_free_in;
         remaining_ff  <= remaining_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      pay_ff      <= pay_in;
      own_ff      <= own_in;
      cur_ff      <= cur_in;
      nxt_ff      <= nxt_in;
      sum_ff      <= sum_in;
      dif_ff      <= dif_in;
      prev_ff     <= prev_in;
      bsz_ff      <= bsz_in;
      fa_ff       <= fa_in;
      hal_ff      <= hal_in;
      how_ff      <= how_in;
      ok_ff       <= ok_in;
      off_ff      <= off_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_off_ff  <= rsp_off_in;
      rsp_free_ff <= rsp_free_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_result_offset = rsp_off_ff;
   assign rsp_free_bytes    = rsp_free_ff;

   a_remaining_bound: assert property (@(posedge clock) disable iff (reset)
      remaining_ff <= VW'(HEAP_BYTES))
      else $error("free byte count above heap size");

   a_first_free_range: assert property (@(posedge clock) disable iff (reset)
      !none_free_ff |-> first_free_ff < SPANV)
      else $error("first free pointer outside tag space");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response raised outside done state");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |=> !(state_ff == F_SUB || state_ff == A_NEED)
         || $past(state_ff) == S_IDLE)
      else $error("transaction started while busy");

endmodule
